FILE: src/shs_pkg.sv
// Shared types and constants for the stepper homing sequencer.
`timescale 1ns / 1ps

package shs_pkg;

   // Register index within the CSR space (byte address / 4).
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_HOMING_SPEED     = 3'd0;
   localparam logic [2:0] REG_BACKUP_SPEED     = 3'd1;
   localparam logic [2:0] REG_START_STOP_SPEED = 3'd2;
   localparam logic [2:0] REG_HOME_OFFSET      = 3'd3;
   localparam logic [2:0] REG_HOME_POSITION    = 3'd4;
   localparam logic [2:0] REG_DIR_MODE         = 3'd5;
   localparam logic [2:0] REG_END_SIDE         = 3'd6;
   localparam logic [2:0] REG_HAS_SWITCH       = 3'd7;

   // Direction mode codes.
   localparam logic [1:0] DIR_FIXED0     = 2'd0;
   localparam logic [1:0] DIR_FIXED1     = 2'd1;
   localparam logic [1:0] DIR_SWITCH     = 2'd2;
   localparam logic [1:0] DIR_SWITCH_INV = 2'd3;

   // End side codes.
   localparam logic [1:0] END_NONE    = 2'd0;
   localparam logic [1:0] END_REV_ON  = 2'd1;
   localparam logic [1:0] END_REV_OFF = 2'd2;

   // Input item kinds.
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_HOME = 1'b1;

   // Homing sequence phases.
   typedef enum logic [1:0] {
      PH_STARTING  = 2'd0,
      PH_GOING     = 2'd1,
      PH_REVERSING = 2'd2,
      PH_TO_OFS    = 2'd3
   } phase_type;

   // Configuration register set.
   typedef struct packed {
      logic [15:0]        homing_speed;
      logic [15:0]        backup_speed;
      logic [15:0]        start_stop_speed;
      logic signed [15:0] home_offset;
      logic signed [15:0] home_position;
      logic [1:0]         dir_mode;
      logic [1:0]         end_side;
      logic               has_switch;
   } cfg_type;

endpackage

FILE: src/shs_regs.sv
// APB-style configuration register file for the homing sequencer.
`timescale 1ns / 1ps

module shs_regs
   import shs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_index;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Register writes on the access cycle of a write transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_HOMING_SPEED:     cfg_ff.homing_speed     <= csr_pwdata[15:0];
            REG_BACKUP_SPEED:     cfg_ff.backup_speed     <= csr_pwdata[15:0];
            REG_START_STOP_SPEED: cfg_ff.start_stop_speed <= csr_pwdata[15:0];
            REG_HOME_OFFSET:      cfg_ff.home_offset      <= $signed(csr_pwdata[15:0]);
            REG_HOME_POSITION:    cfg_ff.home_position    <= $signed(csr_pwdata[15:0]);
            REG_DIR_MODE:         cfg_ff.dir_mode         <= csr_pwdata[1:0];
            REG_END_SIDE:         cfg_ff.end_side         <= csr_pwdata[1:0];
            REG_HAS_SWITCH:       cfg_ff.has_switch       <= csr_pwdata[0];
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // Read data mux; signed registers return their raw 16 bits.
   always_comb begin
      unique case (reg_index)
         REG_HOMING_SPEED:     csr_prdata = {16'd0, cfg_ff.homing_speed};
         REG_BACKUP_SPEED:     csr_prdata = {16'd0, cfg_ff.backup_speed};
         REG_START_STOP_SPEED: csr_prdata = {16'd0, cfg_ff.start_stop_speed};
         REG_HOME_OFFSET:      csr_prdata = {16'd0, cfg_ff.home_offset};
         REG_HOME_POSITION:    csr_prdata = {16'd0, cfg_ff.home_position};
         REG_DIR_MODE:         csr_prdata = {30'd0, cfg_ff.dir_mode};
         REG_END_SIDE:         csr_prdata = {30'd0, cfg_ff.end_side};
         REG_HAS_SWITCH:       csr_prdata = {31'd0, cfg_ff.has_switch};
         default:              csr_prdata = '0;
      endcase
   end

endmodule

FILE: src/stepper_homing_sequencer.sv
// Top level of the stepper homing sequencer: input stage, state update, result register.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      action, start_req, limit_on, position, motor_busy
//   rsp      out        rsp_valid / rsp_stall      speed, dir, status bits, pulses, positions
//   csr      in         APB psel/penable/pready    8 registers at byte address 4*i
//
// Each item passes an input register and then a result register.
// One item can be accepted every cycle while req_stall is low; the state update is combinational.
// Reset clears the sequencer state, the registers and both valid flags.
// A stalled result holds the result register; the input stage then fills and stalls req.
`timescale 1ns / 1ps

module stepper_homing_sequencer
   import shs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input item channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic                  req_start_req,
   input  logic                  req_limit_on,
   input  logic signed [15:0]    req_position,
   input  logic                  req_motor_busy,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_target_speed,
   output logic                  rsp_target_dir,
   output logic                  rsp_homing_active,
   output logic                  rsp_homed,
   output logic                  rsp_busy_set,
   output logic                  rsp_motor_start,
   output logic                  rsp_stop_request,
   output logic                  rsp_position_write,
   output logic signed [15:0]    rsp_position_value,
   output logic signed [15:0]    rsp_test_position,
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // Input stage registers.
   logic               in_valid_ff;
   logic               in_action_ff;
   logic               in_start_ff;
   logic               in_limit_ff;
   logic signed [15:0] in_position_ff;
   logic               in_busy_ff;

   // Sequencer state and its next values.
   phase_type          phase_ff, phase_in;
   logic               active_ff, active_in;
   logic               go_dir_ff, go_dir_in;
   logic               will_reverse_ff, will_reverse_in;
   logic               homed_ff, homed_in;
   logic [15:0]        speed_ff, speed_in;
   logic               dir_ff, dir_in;
   logic signed [15:0] captured_ff, captured_in;

   // Per-item pulses.
   logic               busy_set_c;
   logic               motor_start_c;
   logic               stop_req_c;
   logic               pos_wr_c;
   logic signed [15:0] pos_val_c;
   logic               offset_reached;

   // Result register.
   logic               rsp_valid_ff;
   logic               busy_set_ff;
   logic               motor_start_ff;
   logic               stop_req_ff;
   logic               pos_wr_ff;
   logic signed [15:0] pos_val_ff;

   logic               out_ready;
   logic               advance;
   logic               in_load;

   shs_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline flow control.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign in_load   = req_valid && !req_stall;

   // Input stage: holds the item until the result register can take it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_action_ff   <= req_action;
         in_start_ff    <= req_start_req;
         in_limit_ff    <= req_limit_on;
         in_position_ff <= req_position;
         in_busy_ff     <= req_motor_busy;
      end
   end

   // Sequencer state register, updated once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_STARTING;
         active_ff       <= 1'b0;
         go_dir_ff       <= 1'b0;
         will_reverse_ff <= 1'b0;
         homed_ff        <= 1'b0;
         speed_ff        <= '0;
         dir_ff          <= 1'b0;
         captured_ff     <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         active_ff       <= active_in;
         go_dir_ff       <= go_dir_in;
         will_reverse_ff <= will_reverse_in;
         homed_ff        <= homed_in;
         speed_ff        <= speed_in;
         dir_ff          <= dir_in;
         captured_ff     <= captured_in;
      end
   end

   // Finish test: homing ends once the position crosses the offset in the run direction.
   assign offset_reached = (in_position_ff >= cfg.home_offset) != go_dir_ff;

   // Next state and pulses for the item in the input stage.
   always_comb begin
      phase_in        = phase_ff;
      active_in       = active_ff;
      go_dir_in       = go_dir_ff;
      will_reverse_in = will_reverse_ff;
      homed_in        = homed_ff;
      speed_in        = speed_ff;
      dir_in          = dir_ff;
      captured_in     = captured_ff;
      busy_set_c      = 1'b0;
      motor_start_c   = 1'b0;
      stop_req_c      = 1'b0;
      pos_wr_c        = 1'b0;
      pos_val_c       = '0;

      if (in_action_ff == ACT_HOME) begin
         motor_start_c = !in_busy_ff;
         if (in_start_ff && cfg.has_switch) begin
            // Arm a homing run.
            active_in = 1'b1;
            phase_in  = PH_STARTING;
            unique case (cfg.dir_mode)
               DIR_FIXED0:     go_dir_in = 1'b0;
               DIR_FIXED1:     go_dir_in = 1'b1;
               DIR_SWITCH:     go_dir_in = in_limit_ff;
               DIR_SWITCH_INV: go_dir_in = !in_limit_ff;
               default:        go_dir_in = 1'b0;
            endcase
            will_reverse_in = ((cfg.end_side == END_REV_ON) && in_limit_ff) ||
                              ((cfg.end_side == END_REV_OFF) && !in_limit_ff);
            busy_set_c      = 1'b1;
         end else begin
            // Without a switch or a start request the motor is homed in place.
            stop_req_c = 1'b1;
            pos_wr_c   = 1'b1;
            pos_val_c  = cfg.home_position;
            homed_in   = 1'b1;
         end
      end else if (active_ff) begin
         unique case (phase_ff)
            PH_STARTING: begin
               speed_in = cfg.homing_speed;
               dir_in   = go_dir_ff;
               phase_in = PH_GOING;
            end
            PH_GOING: begin
               if (in_limit_ff != will_reverse_ff) begin
                  homed_in = 1'b0;
                  if (will_reverse_ff) begin
                     // Started on the wrong side: restart the other way.
                     will_reverse_in = 1'b0;
                     go_dir_in       = !go_dir_ff;
                     phase_in        = PH_STARTING;
                  end else begin
                     dir_in   = !go_dir_ff;
                     speed_in = cfg.backup_speed;
                     phase_in = PH_REVERSING;
                  end
               end
            end
            PH_REVERSING: begin
               if (!in_limit_ff) begin
                  captured_in = in_position_ff;
                  pos_wr_c    = 1'b1;
                  pos_val_c   = '0;
                  phase_in    = PH_TO_OFS;
               end
            end
            PH_TO_OFS: begin
               if (offset_reached) begin
                  active_in  = 1'b0;
                  homed_in   = 1'b1;
                  pos_wr_c   = 1'b1;
                  pos_val_c  = cfg.home_position;
                  stop_req_c = 1'b1;
               end
            end
            default: begin
               phase_in = PH_STARTING;
            end
         endcase
      end
   end

   // Result register: valid flag and per-item pulses.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         busy_set_ff    <= busy_set_c;
         motor_start_ff <= motor_start_c;
         stop_req_ff    <= stop_req_c;
         pos_wr_ff      <= pos_wr_c;
         pos_val_ff     <= pos_val_c;
      end
   end

   // State-derived fields read straight from the state registers, which move only on advance.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_speed   = speed_ff;
   assign rsp_target_dir     = dir_ff;
   assign rsp_homing_active  = active_ff;
   assign rsp_homed          = homed_ff;
   assign rsp_busy_set       = busy_set_ff;
   assign rsp_motor_start    = motor_start_ff;
   assign rsp_stop_request   = stop_req_ff;
   assign rsp_position_write = pos_wr_ff;
   assign rsp_position_value = pos_val_ff;
   assign rsp_test_position  = captured_ff;

`ifndef SYNTHESIS
   // Arming a run always leaves the sequence active.
   a_busy_set_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && busy_set_ff |-> active_ff)
      else $error("busy_set without an active homing run");

   // A stop always comes with a position write and the homed flag.
   a_stop_homed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && stop_req_ff |-> pos_wr_ff && homed_ff)
      else $error("stop_request without position write and homed");

   // An item moved out of the input stage shows up as a valid result.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

   // No position value is presented without a position write.
   a_pos_val_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pos_wr_ff |-> pos_val_ff == 16'sd0)
      else $error("position_value nonzero without position_write");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the stepper homing sequencer: random and directed transfers.
`timescale 1ns / 1ps

module testbench
   import shs_pkg::*;
();

   // One input item as carried by the request channel.
   typedef struct packed {
      logic               action;
      logic               start_req;
      logic               limit_on;
      logic signed [15:0] position;
      logic               motor_busy;
   } homing_item_type;

   // One result item as carried by the response channel.
   typedef struct packed {
      logic [15:0]        target_speed;
      logic               target_dir;
      logic               homing_active;
      logic               homed;
      logic               busy_set;
      logic               motor_start;
      logic               stop_request;
      logic               position_write;
      logic signed [15:0] position_value;
      logic signed [15:0] test_position;
   } homing_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = 1'b0;
   logic                  req_start_req = 1'b0;
   logic                  req_limit_on = 1'b0;
   logic signed [15:0]    req_position = '0;
   logic                  req_motor_busy = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [15:0]           rsp_target_speed;
   logic                  rsp_target_dir;
   logic                  rsp_homing_active;
   logic                  rsp_homed;
   logic                  rsp_busy_set;
   logic                  rsp_motor_start;
   logic                  rsp_stop_request;
   logic                  rsp_position_write;
   logic signed [15:0]    rsp_position_value;
   logic signed [15:0]    rsp_test_position;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   stepper_homing_sequencer uut (.*);

   // Items waiting to be sent and results waiting to arrive.
   homing_item_type   pending_items[$];
   homing_result_type expected_results[$];

   // Shadow copy of the registers and of the sequencer state.
   cfg_type        regs = '0;
   phase_type      hs_phase = PH_STARTING;
   logic           hs_active = 1'b0;
   logic           hs_go_dir = 1'b0;
   logic           hs_reverse = 1'b0;
   logic           hs_homed = 1'b0;
   logic [15:0]    hs_speed = '0;
   logic           hs_dir = 1'b0;
   logic [15:0]    hs_capture = '0;

   int             send_idle_pct = 28;
   int             recv_idle_pct = 73;
   bit             req_accepted = 1'b0;
   int             failures = 0;
   int             items_accepted = 0;
   int             results_checked = 0;
   int             runs_completed = 0;
   int             fake_homings = 0;
   int             settings_used = 0;

   // Free-running clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Advance the shadow sequencer by one item and return the result it produces.
   function automatic homing_result_type homing_step(homing_item_type it);
      homing_result_type r;
      r = '0;
      if (it.action == ACT_HOME) begin
         r.motor_start = !it.motor_busy;
         if (it.start_req && regs.has_switch) begin
            hs_active = 1'b1;
            hs_phase = PH_STARTING;
            case (regs.dir_mode)
               DIR_FIXED0: hs_go_dir = 1'b0;
               DIR_FIXED1: hs_go_dir = 1'b1;
               DIR_SWITCH: hs_go_dir = it.limit_on;
               default:    hs_go_dir = !it.limit_on;
            endcase
            hs_reverse = (regs.end_side == END_REV_ON && it.limit_on) ||
                         (regs.end_side == END_REV_OFF && !it.limit_on);
            r.busy_set = 1'b1;
         end else begin
            // No switch or no start: declare the motor homed where it stands.
            r.stop_request = 1'b1;
            r.position_write = 1'b1;
            r.position_value = regs.home_position;
            hs_homed = 1'b1;
            fake_homings++;
         end
      end else if (hs_active) begin
         case (hs_phase)
            PH_STARTING: begin
               hs_speed = regs.homing_speed;
               hs_dir = hs_go_dir;
               hs_phase = PH_GOING;
            end
            PH_GOING: begin
               if (it.limit_on != hs_reverse) begin
                  hs_homed = 1'b0;
                  if (hs_reverse) begin
                     // Started on the wrong side: restart the other way.
                     hs_reverse = 1'b0;
                     hs_go_dir = !hs_go_dir;
                     hs_phase = PH_STARTING;
                  end else begin
                     hs_dir = !hs_go_dir;
                     hs_speed = regs.backup_speed;
                     hs_phase = PH_REVERSING;
                  end
               end
            end
            PH_REVERSING: begin
               if (!it.limit_on) begin
                  hs_capture = it.position;
                  r.position_write = 1'b1;
                  r.position_value = '0;
                  hs_phase = PH_TO_OFS;
               end
            end
            default: begin
               if (($signed(it.position) >= $signed(regs.home_offset)) != hs_go_dir) begin
                  hs_active = 1'b0;
                  hs_homed = 1'b1;
                  r.position_write = 1'b1;
                  r.position_value = regs.home_position;
                  r.stop_request = 1'b1;
                  runs_completed++;
               end
            end
         endcase
      end
      r.target_speed = hs_speed;
      r.target_dir = hs_dir;
      r.homing_active = hs_active;
      r.homed = hs_homed;
      r.test_position = hs_capture;
      return r;
   endfunction

   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         failures++;
      end
   endtask

   // Request driver: a new item goes out only after the previous transfer.
   always @(negedge clock) begin : drive_requests
      homing_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_action <= next_item.action;
            req_start_req <= next_item.start_req;
            req_limit_on <= next_item.limit_on;
            req_position <= next_item.position;
            req_motor_busy <= next_item.motor_busy;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Monitor: predict on each request transfer, check each response transfer.
   always @(posedge clock) begin : monitor
      homing_item_type   seen;
      homing_result_type want;
      req_accepted = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_accepted = 1'b1;
            items_accepted++;
            seen.action = req_action;
            seen.start_req = req_start_req;
            seen.limit_on = req_limit_on;
            seen.position = req_position;
            seen.motor_busy = req_motor_busy;
            expected_results.push_back(homing_step(seen));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response transfer with no item outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               check_field("target_speed", want.target_speed, rsp_target_speed);
               check_field("target_dir", want.target_dir, rsp_target_dir);
               check_field("homing_active", want.homing_active, rsp_homing_active);
               check_field("homed", want.homed, rsp_homed);
               check_field("busy_set", want.busy_set, rsp_busy_set);
               check_field("motor_start", want.motor_start, rsp_motor_start);
               check_field("stop_request", want.stop_request, rsp_stop_request);
               check_field("position_write", want.position_write, rsp_position_write);
               check_field("position_value", want.position_value, rsp_position_value);
               check_field("test_position", want.test_position, rsp_test_position);
            end
         end
      end
   end

   task automatic queue_item(bit action, bit start, bit lim, int pos, bit busy);
      homing_item_type it;
      it.action = action;
      it.start_req = start;
      it.limit_on = lim;
      it.position = pos[15:0];
      it.motor_busy = busy;
      pending_items.push_back(it);
   endtask

   // Register write over the APB port; the shadow copy follows it.
   task automatic csr_write(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_HOMING_SPEED:     regs.homing_speed = value;
         REG_BACKUP_SPEED:     regs.backup_speed = value;
         REG_START_STOP_SPEED: regs.start_stop_speed = value;
         REG_HOME_OFFSET:      regs.home_offset = value;
         REG_HOME_POSITION:    regs.home_position = value;
         REG_DIR_MODE:         regs.dir_mode = value[1:0];
         REG_END_SIDE:         regs.end_side = value[1:0];
         default:              regs.has_switch = value[0];
      endcase
   endtask

   task automatic program_registers(cfg_type s);
      csr_write(REG_HOMING_SPEED, s.homing_speed);
      csr_write(REG_BACKUP_SPEED, s.backup_speed);
      csr_write(REG_START_STOP_SPEED, s.start_stop_speed);
      csr_write(REG_HOME_OFFSET, s.home_offset);
      csr_write(REG_HOME_POSITION, s.home_position);
      csr_write(REG_DIR_MODE, {14'h0000, s.dir_mode});
      csr_write(REG_END_SIDE, {14'h0000, s.end_side});
      csr_write(REG_HAS_SWITCH, {15'h0000, s.has_switch});
      settings_used++;
      @(posedge clock);
      #1;
   endtask

   // Wait until every item has gone out and every result has come back.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   // Mostly positions close to the offset, so the finish compare flips often.
   function automatic int pick_position();
      if ($urandom_range(0, 4) == 0)
         return $urandom();
      return $signed(regs.home_offset) + $urandom_range(0, 16) - 8;
   endfunction

   // A home command followed by ticks with a wandering switch level.
   task automatic add_homing_run(inout int count);
      bit lim;
      int ticks;
      lim = $urandom_range(0, 1);
      queue_item(ACT_HOME, $urandom_range(0, 9) != 0, lim, $urandom(), $urandom_range(0, 1));
      ticks = $urandom_range(3, 16);
      repeat (ticks) begin
         if ($urandom_range(0, 2) == 0)
            lim = !lim;
         queue_item(ACT_TICK, $urandom_range(0, 1), lim, pick_position(),
                    $urandom_range(0, 1));
      end
      count += ticks + 1;
   endtask

   // Stimulus: reset, a directed sequence, then random phases under new settings.
   initial begin : stimulus
      cfg_type s;
      int      added;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      s.homing_speed = 16'd1234;
      s.backup_speed = 16'h00FF;
      s.start_stop_speed = 16'd7;
      s.home_offset = 16'sd0;
      s.home_position = -16'sd5;
      s.dir_mode = DIR_SWITCH;
      s.end_side = END_REV_ON;
      s.has_switch = 1'b1;
      program_registers(s);

      // Directed walk through every phase of a homing run.
      queue_item(ACT_TICK, 1, 1, 32767, 1);    // tick while idle
      queue_item(ACT_HOME, 0, 0, -32768, 1);   // fake homing while moving
      queue_item(ACT_HOME, 1, 1, 0, 0);        // armed on the switch, reverse flag set
      queue_item(ACT_TICK, 0, 1, 0, 0);        // starting
      queue_item(ACT_TICK, 0, 1, 0, 0);        // going, switch matches reverse flag
      queue_item(ACT_TICK, 0, 0, 0, 0);        // wrong side: restart the other way
      queue_item(ACT_TICK, 0, 0, 0, 0);        // starting again
      queue_item(ACT_TICK, 0, 0, 0, 0);        // going, no switch yet
      queue_item(ACT_TICK, 0, 1, 0, 0);        // switch hit: back off
      queue_item(ACT_TICK, 0, 1, 0, 0);        // still on the switch
      queue_item(ACT_TICK, 0, 0, 32767, 0);    // release: capture and zero
      queue_item(ACT_TICK, 0, 0, -32768, 0);   // below the offset
      queue_item(ACT_TICK, 0, 0, 32767, 0);    // offset reached
      queue_item(ACT_TICK, 0, 0, 0, 1);        // idle again
      queue_item(ACT_HOME, 1, 0, -1, 1);       // armed off the switch
      queue_item(ACT_TICK, 0, 0, 0, 0);
      queue_item(ACT_HOME, 1, 1, 1, 0);        // re-armed while active
      queue_item(ACT_HOME, 0, 1, 0, 0);        // fake homing while active
      queue_item(ACT_TICK, 0, 1, 0, 0);
      queue_item(ACT_TICK, 0, 0, 0, 0);
      queue_item(ACT_TICK, 0, 1, 0, 0);
      queue_item(ACT_TICK, 0, 0, 100, 0);
      queue_item(ACT_TICK, 0, 0, -100, 0);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         if (p == 2) begin
            send_idle_pct = 73;
            recv_idle_pct = 28;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (3) @(posedge clock);

         // Extremes in the first two settings, random values afterward.
         s.homing_speed = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom());
         s.backup_speed = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom());
         s.start_stop_speed = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom());
         s.home_offset = (p == 0) ? 16'h7FFF : (p == 1) ? 16'h8000 : 16'($urandom());
         s.home_position = (p == 0) ? 16'h8000 : (p == 1) ? 16'h7FFF : 16'($urandom());
         s.dir_mode = 2'(p);
         s.end_side = 2'(p * 3 + 1);
         s.has_switch = (p != 3);
         program_registers(s);

         added = 0;
         while (added < 200) begin
            if ($urandom_range(0, 99) < 85) begin
               add_homing_run(added);
            end else begin
               queue_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom(), $urandom_range(0, 1));
               added++;
            end
         end
         wait_drained();
      end

      repeat (6) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         failures++;
      end
      $display("Checked %0d result transfers for %0d accepted items under %0d settings.",
               results_checked, items_accepted, settings_used);
      $display("Homing runs completed: %0d; immediate homings: %0d.",
               runs_completed, fake_homings);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
